// ===== rtl/sose_pkg.sv =====
// Package for the scroll offset SSD estimator: shared types, constants and gray conversion.
// No dependencies.
package sose_pkg;
  localparam int unsigned GRAY_B = 114;
  localparam int unsigned GRAY_G = 587;
  localparam int unsigned GRAY_R = 299;
  // ceil(2^28/1000), exact quotient for numerators below 256000
  localparam int unsigned GRAY_RECIP = 268436;
  localparam int unsigned GRAY_SHIFT = 28;
  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] old_gray;
    logic [7:0] new_gray;
    logic       last;
  } pix_t;

  // (b*114+g*587+r*299)/1000 by reciprocal multiply, numerator < 256000
  function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [17:0] v;
    logic [36:0] p;
    begin
      v = 18'(b * GRAY_B) + 18'(g * GRAY_G) + 18'(r * GRAY_R);
      p = 37'(v) * 37'(GRAY_RECIP);
      to_gray = 8'(p >> GRAY_SHIFT);
    end
  endfunction
endpackage

// ===== rtl/sose_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sose_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sose_front.sv =====
// Front end: accepts pixel beats, converts to gray and queues them.
// Depends on sose_pkg.
module sose_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       ob, og, orr, nb, ng, nr,
  input  logic             last,
  output logic             q_valid,
  input  logic             q_ready,
  output sose_pkg::pix_t   q_data
);
  sose_pkg::pix_t buf0, buf1;
  logic [1:0] cnt;
  logic push, pop;
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = buf0;
  sose_pkg::pix_t nw;
  always_comb begin
    nw.old_gray = sose_pkg::to_gray(ob, og, orr);
    nw.new_gray = sose_pkg::to_gray(nb, ng, nr);
    nw.last = last;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (pop) begin
      if (cnt == 2'd2) buf0 <= buf1;
      else if (push) buf0 <= nw;
      if (push && cnt == 2'd2) buf1 <= nw;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= nw;
      else buf1 <= nw;
    end
  end
endmodule

// ===== rtl/sose_back.sv =====
// Back end: stores gray pixels and runs the shift search sequencer.
// Depends on sose_pkg and sose_ram.
module sose_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_STRIP_ROWS = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [11:0]          cfg_w,
  input  logic [7:0]           cfg_h,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sose_pkg::pix_t       q_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [6:0]           scroll_rows,
  output logic [33:0]          best_error_sum,
  output logic [7:0]           best_row_count
);
  localparam int DEPTH = MAX_WIDTH * MAX_STRIP_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_STRIP_ROWS + 1);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001, S_SET = 6'b000010, S_RUN = 6'b000100,
    S_CMP  = 6'b001000, S_DEC = 6'b010000, S_OUT = 6'b100000
  } st_t;
  st_t st;

  logic [AW-1:0] lpos;
  logic [XW-1:0] w, x;
  logic [RW-1:0] h, s, r, rows;
  logic [AW:0]   ia, ib;
  logic [33:0]   sum, sum0, bsum;
  logic [RW-1:0] brows, bs;
  logic [7:0]    od, nd;
  logic          pv, pv2, pok, pok2;
  logic [16:0]   sq;
  logic          run_done;

  logic we;
  assign we = (st == S_LOAD) && q_valid;
  assign q_ready = (st == S_LOAD);

  sose_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_old (
    .clk, .we, .waddr(lpos), .wdata(q_data.old_gray), .raddr(ia[AW-1:0]), .rdata(od));
  sose_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_new (
    .clk, .we, .waddr(lpos), .wdata(q_data.new_gray), .raddr(ib[AW-1:0]), .rdata(nd));

  logic [8:0] d;
  assign d = {1'b0, od} - {1'b0, nd};
  assign run_done = (r == rows);

  // cross products for compare and decision
  logic [47:0] p1, p2;
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_LOAD; lpos <= '0; res_valid <= 1'b0; pv <= 1'b0; pv2 <= 1'b0;
    end else begin
      pv <= 1'b0;
      pv2 <= pv;
      pok2 <= pok;
      unique case (st)
        S_LOAD: if (q_valid) begin
          lpos <= (lpos == AW'(DEPTH - 1)) ? '0 : lpos + 1'b1;
          if (q_data.last) begin
            w <= (cfg_w == 0) ? XW'(1) : (cfg_w > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg_w);
            h <= (cfg_h == 0) ? RW'(1) : (cfg_h > MAX_STRIP_ROWS) ? RW'(MAX_STRIP_ROWS)
                 : RW'(cfg_h);
            s <= '0;
            st <= S_SET;
          end
        end
        S_SET: begin
          rows <= h - s; r <= '0; x <= '0; sum <= '0;
          ia <= (AW+1)'(s) * (AW+1)'(w); ib <= '0;
          st <= S_RUN;
        end
        S_RUN: begin
          if (!run_done) begin
            pv <= 1'b1;
            pok <= (ia < (AW+1)'(DEPTH)) && (ib < (AW+1)'(DEPTH));
            ia <= ia + 1'b1; ib <= ib + 1'b1;
            if (x == w - 1'b1) begin x <= '0; r <= r + 1'b1; end
            else x <= x + 1'b1;
          end else if (!pv && !pv2) begin
            p1 <= 48'(sum) * 48'(brows);
            p2 <= 48'(bsum) * 48'(rows);
            st <= S_CMP;
          end
        end
        S_CMP: begin
          if (s == 0) begin
            sum0 <= sum; bsum <= sum; brows <= rows; bs <= '0;
          end else if (p1 < p2) begin
            bsum <= sum; brows <= rows; bs <= s;
          end
          if (s == h - 1'b1) st <= S_DEC;
          else begin s <= s + 1'b1; st <= S_SET; end
        end
        S_DEC: begin
          p1 <= 48'(bsum) * 48'(h);
          p2 <= 48'(sum0) * 48'(brows);
          st <= S_OUT;
        end
        S_OUT: if (!res_valid) begin
          res_valid <= 1'b1;
          best_error_sum <= bsum;
          best_row_count <= 8'(brows);
          if (bs == 0 || 52'(p1) * 52'd10 >= 52'(p2) * 52'd9
              || 50'(bsum) > 50'(brows) * 50'd40000) scroll_rows <= '0;
          else scroll_rows <= 7'(bs);
        end else if (res_ready) begin
          res_valid <= 1'b0; lpos <= '0; st <= S_LOAD;
        end
        default: st <= S_LOAD;
      endcase
      if (pv2 && pok2) sum <= sum + 34'(sq);
    end
    sq <= 17'($signed(d) * $signed(d));
  end

  assert property (@(posedge clk) disable iff (rst) res_valid |-> st == S_OUT)
    else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst) q_ready |-> !res_valid)
    else $error("loading while result pending");
  assert property (@(posedge clk) disable iff (rst) (st == S_RUN) |-> r <= rows)
    else $error("row counter overran");
endmodule

// ===== rtl/scroll_offset_ssd_estimator.sv =====
// Top level of the scroll offset SSD estimator: config registers, front, back.
// Depends on sose_pkg, sose_front, sose_back.
// Loading: one pixel beat per cycle through a two-entry queue, while the back end loads.
// Search: for each shift s, width*(h-s) stored pixel pairs are read, one pair per cycle
// (store read port).
// Result after the search; next load waits until the result beat is taken.
// Synchronous reset: width 2048, height 100, load position 0; stores are not cleared.
module scroll_offset_ssd_estimator #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_STRIP_ROWS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  old_blue, old_green, old_red,
  input  logic [7:0]  new_blue, new_green, new_red,
  input  logic        final_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  scroll_rows,
  output logic [33:0] best_error_sum,
  output logic [7:0]  best_row_count
);
  logic [11:0] strip_width;
  logic [7:0]  strip_height;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      strip_width <= 12'd2048; strip_height <= 8'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sose_pkg::CFG_WIDTH:  strip_width <= cfg_data;
        sose_pkg::CFG_HEIGHT: strip_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_ready;
  sose_pkg::pix_t q_data;
  sose_front u_front (
    .clk, .rst, .in_valid, .in_ready, .ob(old_blue), .og(old_green), .orr(old_red),
    .nb(new_blue), .ng(new_green), .nr(new_red), .last(final_pixel),
    .q_valid, .q_ready, .q_data);
  sose_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_STRIP_ROWS(MAX_STRIP_ROWS)) u_back (
    .clk, .rst, .cfg_w(strip_width), .cfg_h(strip_height), .q_valid, .q_ready, .q_data,
    .res_valid(out_valid), .res_ready(out_ready), .scroll_rows, .best_error_sum,
    .best_row_count);
endmodule

// ===== dv/scroll_shift_checker.sv =====
// Checker for the scroll offset SSD estimator: mirrors the gray stores and registers,
// predicts the best vertical shift per strip pair and compares every result beat.
// Depends on sose_pkg.
module scroll_shift_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  old_blue, old_green, old_red,
  input  logic [7:0]  new_blue, new_green, new_red,
  input  logic        final_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  scroll_rows,
  input  logic [33:0] best_error_sum,
  input  logic [7:0]  best_row_count,
  output int unsigned mismatches,
  output int unsigned awaited
);
  localparam int unsigned DEPTH = 2048 * 128;

  typedef struct packed {
    logic [6:0]  rows_moved;
    logic [33:0] err_sum;
    logic [7:0]  row_count;
  } shift_verdict_t;

  logic [7:0]  old_luma [DEPTH];
  logic [7:0]  new_luma [DEPTH];
  int unsigned wr_pos;
  logic [11:0] width_reg;
  logic [7:0]  height_reg;
  shift_verdict_t pending_shifts[$];

  function automatic logic [7:0] luma(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
    int unsigned v;
    v = b * 114 + g * 587 + r * 299;
    return 8'(v / 1000);
  endfunction

  task automatic predict_best_shift();
    int unsigned w, h, s, r, x, rows, best_s, best_rows;
    longint unsigned sum, sum0, best_sum;
    int d;
    shift_verdict_t v;
    w = (width_reg == 0) ? 1 : ((width_reg > 2048) ? 2048 : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > 128) ? 128 : height_reg);
    sum0 = 0;
    best_sum = 0;
    best_rows = h;
    best_s = 0;
    for (s = 0; s < h; s++) begin
      rows = h - s;
      sum = 0;
      for (r = 0; r < rows; r++)
        for (x = 0; x < w; x++) begin
          d = int'(old_luma[(s + r) * w + x]) - int'(new_luma[r * w + x]);
          sum += longint'(d * d);
        end
      if (s == 0) begin
        sum0 = sum;
        best_sum = sum;
      end else if (sum * best_rows < best_sum * rows) begin
        best_sum = sum;
        best_rows = rows;
        best_s = s;
      end
    end
    v.rows_moved = 7'(best_s);
    if (best_s == 0 || 10 * best_sum * h >= 9 * sum0 * best_rows ||
        best_sum > 40000 * longint'(best_rows))
      v.rows_moved = '0;
    v.err_sum = 34'(best_sum);
    v.row_count = 8'(best_rows);
    pending_shifts.push_back(v);
  endtask

  always @(posedge clk) begin
    shift_verdict_t want;
    if (rst) begin
      wr_pos = 0;
      width_reg = 12'd2048;
      height_reg = 8'd100;
      pending_shifts.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sose_pkg::CFG_WIDTH) width_reg = cfg_data;
        else if (cfg_index == sose_pkg::CFG_HEIGHT) height_reg = cfg_data[7:0];
      end
      if (in_valid && in_ready) begin
        if (wr_pos >= DEPTH) wr_pos = 0;
        old_luma[wr_pos] = luma(old_blue, old_green, old_red);
        new_luma[wr_pos] = luma(new_blue, new_green, new_red);
        wr_pos++;
        if (final_pixel) begin
          predict_best_shift();
          wr_pos = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_shifts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: scroll %0d sum %0d rows %0d",
                     scroll_rows, best_error_sum, best_row_count);
        end else begin
          want = pending_shifts.pop_front();
          if (want.rows_moved !== scroll_rows || want.err_sum !== best_error_sum ||
              want.row_count !== best_row_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: scroll %0d/%0d sum %0d/%0d rows %0d/%0d (exp/act)",
                       want.rows_moved, scroll_rows, want.err_sum, best_error_sum,
                       want.row_count, best_row_count);
          end
        end
      end
    end
    awaited = pending_shifts.size();
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top for the scroll offset SSD estimator: clock, reset, strip stimulus,
// result back-pressure and verdict. Depends on sose_pkg, scroll_shift_checker, the RTL.
module tb;
  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [0:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_valid, in_ready;
  logic [7:0]  old_blue, old_green, old_red, new_blue, new_green, new_red;
  logic        final_pixel;
  logic        out_valid, out_ready;
  logic [6:0]  scroll_rows;
  logic [33:0] best_error_sum;
  logic [7:0]  best_row_count;
  int unsigned mismatches, awaited;

  int unsigned strip_w, strip_h, covered, beats, strips;
  bit calm, hold_req;

  scroll_offset_ssd_estimator dut (.*);

  scroll_shift_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
        out_ready <= 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [11:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h);
    do @(negedge clk); while (awaited != 0);
    repeat (20) @(posedge clk);
    write_reg(sose_pkg::CFG_WIDTH, 12'(w));
    write_reg(sose_pkg::CFG_HEIGHT, 12'(h));
    strip_w = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
    strip_h = (h == 0) ? 1 : ((h > 128) ? 128 : h);
  endtask

  task automatic send(input logic [23:0] o, input logic [23:0] n, input bit fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    {old_blue, old_green, old_red} <= o;
    {new_blue, new_green, new_red} <= n;
    final_pixel <= fin;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    beats++;
    if (fin) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // mode 0 random, 1 shifted copy, 2 saturated channels, 3 flat
  task automatic load_strip(input int unsigned mode);
    int unsigned n, len, k, i, row, col, src;
    logic [23:0] olds[], news[];
    logic [23:0] c0, c1;
    n = strip_w * strip_h;
    len = n;
    case ($urandom_range(0, 9))
      0: if (covered >= n) len = $urandom_range(1, n);
      1: if (n + 3 <= 2048 * 128) len = n + $urandom_range(1, 3);
      default: ;
    endcase
    k = (strip_h > 1) ? $urandom_range(1, strip_h - 1) : 0;
    c0 = $urandom;
    c1 = $urandom_range(0, 1) ? c0 : 24'($urandom);
    olds = new[len];
    news = new[len];
    for (i = 0; i < len; i++)
      case (mode)
        2: olds[i] = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                      {8{$urandom_range(0, 1) == 1}}};
        3: olds[i] = c0;
        default: olds[i] = $urandom;
      endcase
    for (i = 0; i < len; i++) begin
      row = i / strip_w;
      col = i % strip_w;
      src = (row + k) * strip_w + col;
      case (mode)
        1: begin
          news[i] = (k > 0 && src < len) ? olds[src] : 24'($urandom);
          if ($urandom_range(0, 7) == 0) news[i] ^= 24'($urandom_range(0, 7));
        end
        2: news[i] = {{8{$urandom_range(0, 1) == 1}}, {8{$urandom_range(0, 1) == 1}},
                      {8{$urandom_range(0, 1) == 1}}};
        3: news[i] = c1;
        default: news[i] = $urandom;
      endcase
    end
    for (i = 0; i < len; i++) send(olds[i], news[i], i == len - 1);
    if (len > covered) covered = len;
    strips++;
  endtask

  initial begin
    int unsigned mode;
    rst = 1;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; final_pixel = 0;
    {old_blue, old_green, old_red, new_blue, new_green, new_red} = '0;
    calm = 0; hold_req = 0;
    covered = 0; beats = 0; strips = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    configure(1, 1);
    send('1, '0, 1);
    send('0, '1, 1);
    send('0, '0, 1);
    configure(2, 4);
    load_strip(1);
    load_strip(1);
    load_strip(3);
    load_strip(2);
    configure(0, 0);
    load_strip(0);
    configure(64, 2);
    load_strip(0);
    configure(48, 3);
    load_strip(2);
    configure(1, 128);
    load_strip(1);
    configure(1, 255);
    load_strip(0);

    // results held back while strips keep coming
    configure(2, 3);
    hold_req = 1;
    repeat (4) load_strip($urandom_range(0, 3));

    while (beats < 1650) begin
      calm = beats > 1400;
      configure($urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6),
                $urandom_range(0, 3) == 0 ? $urandom_range(1, 24) : $urandom_range(1, 8));
      repeat ($urandom_range(1, 4)) begin
        mode = $urandom_range(0, 5);
        load_strip(mode > 3 ? 1 : mode);
      end
    end

    do @(negedge clk); while (awaited != 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d pixel beats in %0d strip pairs; widths 1..64, heights 1..128,",
             beats, strips);
    $display("zero and oversized register values, short and long loads, long result stall.");
    if (mismatches == 0 && awaited == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sose_pkg.sv
rtl/sose_ram.sv
rtl/sose_front.sv
rtl/sose_back.sv
rtl/scroll_offset_ssd_estimator.sv
dv/scroll_shift_checker.sv
dv/tb.sv
